/* rtl/core/fch_pkg.sv */
package fch_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_SRGB     = 3'd2;
    localparam logic [2:0] CFG_CHAN_A   = 3'd3;
    localparam logic [2:0] CFG_CHAN_B   = 3'd4;
    localparam logic [2:0] CFG_HDR_MODE = 3'd5;

    // Header byte positions walked by the prefix sequencer
    localparam logic [3:0] HDR_SRGB      = 4'd8;
    localparam logic [3:0] HDR_CHAN_A    = 4'd9;
    localparam logic [3:0] HDR_CHAN_B    = 4'd10;

    typedef logic [63:0] t_hash;

endpackage

/* rtl/core/fnv1a_content_hash_top.sv */
// A word accepted waits in the input word register, then folds into the running hash; a
// message's hash is registered for output when its last word folds. Throughput: one byte
// per cycle unless a header is folding or a result is held; the fold is one XOR and a
// shift-add multiply. Reset: synchronous, active low; zeroes the configuration registers,
// then the prefix sequencer folds the 11 header bytes (9 in header mode 1) with tready
// low. Listed register writes restart it; a message in progress keeps its running hash.
module fnv1a_content_hash_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // [63:0] hash_value
);
    import fch_pkg::*;

    // configuration registers
    logic [31:0] r_width;
    logic [31:0] r_height;
    logic        r_srgb;
    logic [7:0]  r_chan_a;
    logic [7:0]  r_chan_b;
    logic        r_hdr_mode;

    // prefix sequencer
    logic        r_busy;
    logic [3:0]  r_seq_idx;
    t_hash       r_hdr_hash;
    t_hash       r_prefix;

    // input word register and running hash
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    t_hash       r_run;
    logic        r_idle;

    // result register
    logic        r_out_valid;
    t_hash       r_out_hash;

    logic        cfg_hit;
    logic [7:0]  hdr_byte;
    logic [3:0]  hdr_last_idx;
    logic        seq_done;
    logic        advance;
    t_hash       fold_hash;
    t_hash       hdr_fold_hash;

    // A write to an index beyond the list changes nothing
    always_comb begin
        unique case (i_cfg_addr)
            CFG_WIDTH, CFG_HEIGHT, CFG_SRGB,
            CFG_CHAN_A, CFG_CHAN_B, CFG_HDR_MODE: cfg_hit = i_cfg_we;
            default:                              cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= '0;
            r_height   <= '0;
            r_srgb     <= 1'b0;
            r_chan_a   <= '0;
            r_chan_b   <= '0;
            r_hdr_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WIDTH:    r_width    <= i_cfg_wdata;
                CFG_HEIGHT:   r_height   <= i_cfg_wdata;
                CFG_SRGB:     r_srgb     <= i_cfg_wdata[0];
                CFG_CHAN_A:   r_chan_a   <= i_cfg_wdata[7:0];
                CFG_CHAN_B:   r_chan_b   <= i_cfg_wdata[7:0];
                CFG_HDR_MODE: r_hdr_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Header byte under the sequencer: width and height little-endian, then
    // the sRGB byte, then the two channel bytes in channel mode
    always_comb begin
        case (r_seq_idx)
            4'd0:       hdr_byte = r_width[7:0];
            4'd1:       hdr_byte = r_width[15:8];
            4'd2:       hdr_byte = r_width[23:16];
            4'd3:       hdr_byte = r_width[31:24];
            4'd4:       hdr_byte = r_height[7:0];
            4'd5:       hdr_byte = r_height[15:8];
            4'd6:       hdr_byte = r_height[23:16];
            4'd7:       hdr_byte = r_height[31:24];
            HDR_SRGB:   hdr_byte = {7'd0, r_srgb};
            HDR_CHAN_A: hdr_byte = r_chan_a;
            HDR_CHAN_B: hdr_byte = r_chan_b;
            default:    hdr_byte = 8'd0;
        endcase
    end

    assign hdr_last_idx = r_hdr_mode ? HDR_SRGB : HDR_CHAN_B;
    assign seq_done     = r_busy && (r_seq_idx == hdr_last_idx);

    // Advance the input word into the hash unless it is a last word and the
    // result register is still held by the sink
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_busy && (!r_in_valid || advance);

    // Data bytes fold into the running hash; header bytes fold into their own
    // accumulator so a message in progress is left alone
    fch_fold u_fold (
        .i_hash (r_run),
        .i_byte (r_in_byte),
        .o_hash (fold_hash)
    );

    fch_fold u_hdr_fold (
        .i_hash (r_hdr_hash),
        .i_byte (hdr_byte),
        .o_hash (hdr_fold_hash)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_seq_idx <= '0;
        end else if (cfg_hit) begin
            r_busy    <= 1'b1;
            r_seq_idx <= '0;
        end else if (seq_done) begin
            r_busy    <= 1'b0;
        end else if (r_busy) begin
            r_seq_idx <= r_seq_idx + 4'd1;
        end
    end

    // Header accumulator: restart from the basis on a write, fold while busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_hdr_hash <= FNV_BASIS;
        end else if (r_busy) begin
            r_hdr_hash <= hdr_fold_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_prefix <= hdr_fold_hash;
        end
    end

    // Running hash: fold data and reload the prefix after a last word; between
    // messages, pick up a freshly folded prefix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= FNV_BASIS;
        end else if (advance) begin
            r_run <= r_in_last ? r_prefix : fold_hash;
        end else if (seq_done && r_idle) begin
            r_run <= hdr_fold_hash;
        end
    end

    // Between messages until a word that is not last is folded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle <= 1'b1;
        end else if (advance) begin
            r_idle <= r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_hash <= fold_hash;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_hash;

`ifndef SYNTH
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_s_axis_tready)
        else $error("input accepted while the header prefix is being folded");

    a_write_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_busy && (r_seq_idx == 4'd0) && (r_hdr_hash == FNV_BASIS)))
        else $error("register write did not restart the prefix sequence");

    a_prefix_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (seq_done && !cfg_hit && r_idle && !advance) |=> (!r_busy && (r_run == r_prefix)))
        else $error("running hash not loaded with the prefix at sequence end");

    a_seq_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_seq_idx <= hdr_last_idx))
        else $error("prefix sequencer ran past the last header byte");
`endif

endmodule

/* rtl/core/fch_fold.sv */
module fch_fold (
    input  fch_pkg::t_hash i_hash,
    input  logic [7:0]     i_byte,
    output fch_pkg::t_hash o_hash
);
    import fch_pkg::*;

    t_hash x;

    // Multiply by the prime 2^40 + 0x1b3 as a shift-add, modulo 2^64
    assign x      = i_hash ^ {56'd0, i_byte};
    assign o_hash = (x << 40) + x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8);

endmodule

/* tb/sv/fch_hash_checker.sv */
`timescale 1ns / 1ps

// Watches the configuration port and both stream sides, tracks the header
// prefix and the running hash, and compares every hash word against the
// oldest one predicted.
module fch_hash_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [63:0] i_m_axis_tdata,   // [63:0] hash_value
    output int          o_pending,
    output int          o_fail_count
);
    import fch_pkg::*;

    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

    logic [31:0] img_width;
    logic [31:0] img_height;
    logic        srgb;
    logic [7:0]  chan_a;
    logic [7:0]  chan_b;
    logic        skip_chan;
    t_hash       prefix;
    t_hash       running;
    logic        between_msgs;
    int          fails;
    t_hash       expected_hashes[$];

    function automatic t_hash fold(input t_hash h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * FNV_PRIME;
    endfunction

    function automatic t_hash header_hash();
        t_hash acc;
        int    k;
        acc = FNV_BASIS;
        for (k = 0; k < 4; k++) acc = fold(acc, img_width[8*k +: 8]);
        for (k = 0; k < 4; k++) acc = fold(acc, img_height[8*k +: 8]);
        acc = fold(acc, {7'd0, srgb});
        if (!skip_chan) begin
            acc = fold(acc, chan_a);
            acc = fold(acc, chan_b);
        end
        return acc;
    endfunction

    always @(posedge i_clk) begin
        t_hash seen;
        logic  known;
        if (!i_rst_n) begin
            img_width    = '0;
            img_height   = '0;
            srgb         = 1'b0;
            chan_a       = '0;
            chan_b       = '0;
            skip_chan    = 1'b0;
            between_msgs = 1'b1;
            fails        = 0;
            prefix       = header_hash();
            running      = prefix;
            expected_hashes.delete();
        end else begin
            if (i_cfg_we) begin
                known = 1'b1;
                case (i_cfg_addr)
                    CFG_WIDTH:    img_width  = i_cfg_wdata;
                    CFG_HEIGHT:   img_height = i_cfg_wdata;
                    CFG_SRGB:     srgb       = i_cfg_wdata[0];
                    CFG_CHAN_A:   chan_a     = i_cfg_wdata[7:0];
                    CFG_CHAN_B:   chan_b     = i_cfg_wdata[7:0];
                    CFG_HDR_MODE: skip_chan  = i_cfg_wdata[0];
                    default:      known      = 1'b0;
                endcase
                if (known) begin
                    prefix = header_hash();
                    // a message in flight keeps its running hash
                    if (between_msgs) running = prefix;
                end
            end

            if (i_s_axis_tvalid && i_s_axis_tready) begin
                running = fold(running, i_s_axis_tdata);
                if (i_s_axis_tlast) begin
                    expected_hashes.push_back(running);
                    running      = prefix;
                    between_msgs = 1'b1;
                end else begin
                    between_msgs = 1'b0;
                end
            end

            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_hashes.size() == 0) begin
                    $display("%0t: unexpected hash word: expected none, actual %h",
                             $time, i_m_axis_tdata);
                    fails++;
                end else begin
                    seen = expected_hashes.pop_front();
                    if (i_m_axis_tdata !== seen) begin
                        $display("%0t: hash_value mismatch: expected %h, actual %h",
                                 $time, seen, i_m_axis_tdata);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= expected_hashes.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/sv/tb_fnv1a_content_hash_top.sv */
`timescale 1ns / 1ps

module tb_fnv1a_content_hash_top;
    import fch_pkg::*;

    // Indexes past the register list; writes there must leave the header alone.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    localparam int RANDOM_BYTES = 400;
    // Quiet cycles tolerated before the run is declared hung. The slowest legal
    // stretch is a header refold plus a few random stalls per side.
    localparam int QUIET_LIMIT  = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [7:0] data_byte
    logic        i_s_axis_tlast;   // last_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [63:0] o_m_axis_tdata;   // [63:0] hash_value

    logic gaps_on;
    int   pending_hashes;
    int   fail_count;
    int   bytes_sent;

    fnv1a_content_hash_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    fch_hash_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_pending       (pending_hashes),
        .o_fail_count    (fail_count)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hash consumer: drop ready at random, 8 times in 100, while gaps are enabled.
    always @(posedge i_clk) begin
        i_m_axis_tready <= !gaps_on || ($urandom_range(99) >= 8);
    end

    // Watchdog: end the run once nothing has moved on any port for too long.
    initial begin : watchdog
        int quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // Write one register; the caller lowers the write enable with cfg_done.
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic cfg_done();
        i_cfg_we <= 1'b0;
    endtask

    // Offer one word and hold it until the block takes it. Idle the sender
    // at random first so gaps land both between and inside messages.
    task automatic push_word(input logic [7:0] b, input logic last);
        while (gaps_on && $urandom_range(99) < 8) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_message(input int len);
        int k;
        for (k = 0; k < len; k++) begin
            push_word(8'($urandom_range(255)), k == len - 1);
            bytes_sent++;
        end
    endtask

    // Stop offering words, wait for every predicted hash to come back, then
    // let the pipeline settle before the registers are touched again.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_hashes != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Favor the extremes of a 32-bit register.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Rewrite a random subset of the registers. Full 32-bit data exercises the
    // masking of narrow registers; the odd write may land past the list.
    task automatic shuffle_header();
        if ($urandom_range(1)) cfg_write(CFG_WIDTH, pick_word());
        if ($urandom_range(1)) cfg_write(CFG_HEIGHT, pick_word());
        if ($urandom_range(1)) cfg_write(CFG_SRGB, $urandom);
        if ($urandom_range(1)) cfg_write(CFG_CHAN_A, $urandom);
        if ($urandom_range(1)) cfg_write(CFG_CHAN_B, $urandom);
        if ($urandom_range(1)) cfg_write(CFG_HDR_MODE, $urandom);
        if ($urandom_range(4) == 0) cfg_write(3'($urandom_range(7)), $urandom);
        cfg_done();
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_addr      <= '0;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        i_m_axis_tready <= 1'b0;
        gaps_on         <= 1'b1;
        bytes_sent      = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default header: eleven zero bytes. Single-byte messages at both
        // byte extremes, then a short one with alternating bit patterns.
        push_word(8'h00, 1'b1);
        push_word(8'hff, 1'b1);
        push_word(8'h55, 1'b0);
        push_word(8'haa, 1'b0);
        push_word(8'h01, 1'b0);
        push_word(8'h80, 1'b1);
        drain();

        // All-ones header in channel mode; srgb and mode carry junk upper bits.
        cfg_write(CFG_WIDTH, 32'hffff_ffff);
        cfg_write(CFG_HEIGHT, 32'hffff_ffff);
        cfg_write(CFG_SRGB, 32'hffff_ffff);
        cfg_write(CFG_CHAN_A, 32'hffff_ffff);
        cfg_write(CFG_CHAN_B, 32'hffff_ffff);
        cfg_write(CFG_HDR_MODE, 32'hffff_fffe);
        cfg_done();
        push_word(8'hff, 1'b1);
        push_word(8'h00, 1'b0);
        push_word(8'h7f, 1'b0);
        push_word(8'hfe, 1'b1);
        drain();

        // Channel bytes omitted; writes past the list must change nothing.
        cfg_write(CFG_HDR_MODE, 32'h0000_0001);
        cfg_write(CFG_SPARE_LO, 32'hdead_beef);
        cfg_write(CFG_SPARE_HI, 32'hffff_ffff);
        cfg_done();
        push_word(8'h42, 1'b1);
        push_word(8'h10, 1'b0);
        push_word(8'h20, 1'b0);
        push_word(8'h40, 1'b1);
        drain();

        // Asymmetric width and height values to catch byte-order slips.
        cfg_write(CFG_WIDTH, 32'h1234_5678);
        cfg_write(CFG_HEIGHT, 32'h0000_0100);
        cfg_write(CFG_SRGB, 32'hffff_fffe);
        cfg_write(CFG_CHAN_A, 32'h0000_0001);
        cfg_write(CFG_CHAN_B, 32'h0000_0080);
        cfg_write(CFG_HDR_MODE, 32'h0000_0000);
        cfg_done();
        push_word(8'hc3, 1'b0);
        push_word(8'h3c, 1'b1);
        drain();

        // Random phases: reshuffle the header, then a burst of messages, mostly
        // short with the occasional long one. The middle of the run has no
        // idling on either side.
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            gaps_on <= !(bytes_sent >= 150 && bytes_sent < 260);
            shuffle_header();
            repeat ($urandom_range(6, 2)) begin
                if ($urandom_range(9) == 0)
                    send_message($urandom_range(40, 13));
                else
                    send_message($urandom_range(8, 1));
            end
            drain();
        end

        if (fail_count == 0 && pending_hashes == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/fch_pkg.sv
rtl/core/fch_fold.sv
rtl/core/fnv1a_content_hash_top.sv
tb/sv/fch_hash_checker.sv
tb/sv/tb_fnv1a_content_hash_top.sv
